FILE: hdl/clfa_pkg.sv
// Shared types and constants for the control-link failsafe and arming unit.
// Holds the configuration record, the queued item, the result record and all codes.
// No dependencies.
package clfa_pkg;

    localparam int SEQ_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ELAPSED_W  = 17;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_UNIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TELE_DIV    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FS_ENABLE   = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_ACCEPT  = 3'd0;
    localparam logic [2:0] ST_CORRUPT = 3'd1;
    localparam logic [2:0] ST_FOREIGN = 3'd2;
    localparam logic [2:0] ST_STALE   = 3'd3;
    localparam logic [2:0] ST_TICK    = 3'd4;

    // Item kinds as sorted by the front end
    localparam logic [1:0] K_TICK    = 2'd0;
    localparam logic [1:0] K_CORRUPT = 2'd1;
    localparam logic [1:0] K_FOREIGN = 2'd2;
    localparam logic [1:0] K_PACKET  = 2'd3;

    // Register reset values
    localparam logic [7:0]  OWN_UNIT_RST   = 8'd1;
    localparam logic [15:0] TIMEOUT_RST    = 16'd500;
    localparam logic [14:0] AXIS_LIMIT_RST = 15'd1000;
    localparam logic [7:0]  TELE_DIV_RST   = 8'd5;
    localparam logic        FS_ENABLE_RST  = 1'b1;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'h1FFFF;
    localparam logic [ELAPSED_W-1:0] ELAPSED_RST = {1'b0, TIMEOUT_RST} + 17'd1;

    // Backward jump beyond this is taken as a peer restart
    localparam logic signed [SEQ_W-1:0] NEG_RESTART_JUMP = -16'sd1000;

    typedef struct packed {
        logic [7:0]  own_unit;
        logic [15:0] timeout;
        logic [14:0] axis_limit;
        logic [7:0]  tele_div;
        logic        fs_enable;
    } t_cfg;

    typedef struct packed {
        logic [1:0]              kind;
        logic [SEQ_W-1:0]        seq;
        logic                    flag_armed;
        logic                    flag_calibration;
        logic signed [15:0]      steer;
        logic signed [15:0]      throttle;
        logic [15:0]             brake;
    } t_item;

    typedef struct packed {
        logic [2:0]          status;
        logic                armed;
        logic                failsafe;
        logic                calibrating;
        logic signed [15:0]  drive_steer;
        logic signed [15:0]  drive_throttle;
        logic [15:0]         drive_brake;
        logic signed [15:0]  calib_steer;
        logic                telemetry_request;
        logic [SEQ_W-1:0]    reply_seq;
    } t_result;

endpackage

FILE: hdl/clfa_front.sv
// Front end: takes input transfers and sorts them into tick, corrupt, foreign or packet.
// Depends on clfa_pkg; feeds clfa_queue.
module clfa_front (
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [79:0]         s_axis_tdata,   // crc_ok, packet_unit, seq, flag_armed,
                                                // flag_calibration, steer_in, throttle_in,
                                                // brake_in, zero fill
    input  logic [0:0]          s_axis_tuser,   // opcode
    input  clfa_pkg::t_cfg      i_cfg,
    input  logic                i_q_full,
    output logic                o_push,
    output clfa_pkg::t_item     o_item
);
    import clfa_pkg::*;

    logic       w_crc_ok;
    logic [7:0] w_unit;

    assign w_crc_ok = s_axis_tdata[0];
    assign w_unit   = s_axis_tdata[8:1];

    assign s_axis_tready = !i_q_full;
    assign o_push        = s_axis_tvalid && !i_q_full;

    always_comb begin
        if (s_axis_tuser[0]) begin
            o_item.kind = K_TICK;
        end else if (!w_crc_ok) begin
            o_item.kind = K_CORRUPT;
        end else if (w_unit != i_cfg.own_unit) begin
            o_item.kind = K_FOREIGN;
        end else begin
            o_item.kind = K_PACKET;
        end
        o_item.seq              = s_axis_tdata[24:9];
        o_item.flag_armed       = s_axis_tdata[25];
        o_item.flag_calibration = s_axis_tdata[26];
        o_item.steer            = $signed(s_axis_tdata[42:27]);
        o_item.throttle         = $signed(s_axis_tdata[58:43]);
        o_item.brake            = s_axis_tdata[74:59];
    end

endmodule

FILE: hdl/clfa_queue.sv
// Two-entry queue of classified items between the front end and the back end.
// Depends on clfa_pkg.
module clfa_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  clfa_pkg::t_item  i_item,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output clfa_pkg::t_item  o_item
);
    import clfa_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hdl/clfa_mod.sv
// Restoring remainder unit: sequence number modulo the telemetry divisor, one bit a cycle.
// Depends on clfa_pkg.
module clfa_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [clfa_pkg::SEQ_W-1:0]  i_dividend,
    input  logic [7:0]                  i_divisor,
    output logic                        o_done,
    output logic                        o_rem_zero
);
    import clfa_pkg::*;

    localparam int CNT_W = $clog2(SEQ_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [SEQ_W-1:0] r_dvd;
    logic [7:0]       r_div;
    logic [7:0]       r_rem;
    logic [8:0]       w_part;
    logic [7:0]       n_rem;

    // Shift in the next dividend bit, subtract when it fits
    always_comb begin
        w_part = {r_rem, r_dvd[SEQ_W-1]};
        if (w_part >= {1'b0, r_div}) begin
            n_rem = 8'(w_part - {1'b0, r_div});
        end else begin
            n_rem = w_part[7:0];
        end
    end

    assign o_done     = r_done;
    assign o_rem_zero = (r_rem == 8'd0);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= 8'd0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[SEQ_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SEQ_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: hdl/clfa_back.sv
// Back end: sequence check, link state, arming, calibration, timeout and the result register.
// Depends on clfa_pkg and clfa_mod; drains clfa_queue.
module clfa_back #(
    parameter int COUNTER_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  clfa_pkg::t_cfg     i_cfg,
    input  logic               i_q_empty,
    input  clfa_pkg::t_item    i_item,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output clfa_pkg::t_result  o_result
);
    import clfa_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOD  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]               r_state;
    logic [2:0]               r_status;
    logic                     r_tele;
    logic [SEQ_W-1:0]         r_echo;
    logic                     r_have_seq;
    logic [SEQ_W-1:0]         r_last_seq;
    logic [ELAPSED_W-1:0]     r_elapsed;
    logic                     r_failsafe;
    logic                     r_armed;
    logic                     r_prev_arm;
    logic                     r_calib;
    logic signed [15:0]       r_steer;
    logic signed [15:0]       r_throttle;
    logic [15:0]              r_brake;
    logic signed [15:0]       r_calib_steer;
    logic [COUNTER_WIDTH-1:0] r_reject_cnt [4];
    logic                     r_out_valid;
    t_result                  r_out;

    logic [SEQ_W-1:0]     w_diff;
    logic                 w_seq_ok;
    logic                 w_cal_ok;
    logic                 w_normal_arm;
    logic signed [15:0]   w_lim;
    logic signed [15:0]   w_neg_lim;
    logic signed [15:0]   w_clamped;
    logic [ELAPSED_W-1:0] n_elapsed;
    logic                 w_timed_out;
    logic                 w_mod_start;
    logic                 w_mod_done;
    logic                 w_rem_zero;
    logic                 w_emit;

    assign w_diff   = i_item.seq - r_last_seq;
    assign w_seq_ok = !r_have_seq || ($signed(w_diff) > 16'sd0)
                      || ($signed(w_diff) < NEG_RESTART_JUMP);

    assign w_cal_ok = i_item.flag_calibration && !i_item.flag_armed && !r_armed
                      && (i_item.throttle == 16'sd0) && (i_item.brake == 16'd0);
    assign w_normal_arm = i_item.flag_armed && !i_item.flag_calibration;

    assign w_lim     = $signed({1'b0, i_cfg.axis_limit});
    assign w_neg_lim = -w_lim;
    always_comb begin
        if (i_item.steer > w_lim) begin
            w_clamped = w_lim;
        end else if (i_item.steer < w_neg_lim) begin
            w_clamped = w_neg_lim;
        end else begin
            w_clamped = i_item.steer;
        end
    end

    // Saturating link age
    assign n_elapsed   = (r_elapsed != ELAPSED_MAX) ? r_elapsed + ELAPSED_W'(1) : r_elapsed;
    assign w_timed_out = n_elapsed > {1'b0, i_cfg.timeout};

    assign o_pop       = (r_state == S_IDLE) && !i_q_empty;
    assign w_mod_start = o_pop && (i_item.kind == K_PACKET) && w_seq_ok
                         && (i_cfg.tele_div != 8'd0);
    assign w_emit      = (r_state == S_EMIT) && (!r_out_valid || i_ready);

    clfa_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (i_item.seq),
        .i_divisor  (i_cfg.tele_div),
        .o_done     (w_mod_done),
        .o_rem_zero (w_rem_zero)
    );

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.status            <= r_status;
            r_out.armed             <= r_armed;
            r_out.failsafe          <= r_failsafe;
            r_out.calibrating       <= r_calib;
            r_out.drive_steer       <= r_steer;
            r_out.drive_throttle    <= r_throttle;
            r_out.drive_brake       <= r_brake;
            r_out.calib_steer       <= r_calib_steer;
            r_out.telemetry_request <= r_tele;
            r_out.reply_seq         <= r_echo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_status      <= ST_TICK;
            r_tele        <= 1'b0;
            r_echo        <= '0;
            r_have_seq    <= 1'b0;
            r_last_seq    <= '0;
            r_elapsed     <= ELAPSED_RST;
            r_failsafe    <= 1'b1;
            r_armed       <= 1'b0;
            r_prev_arm    <= 1'b1;
            r_calib       <= 1'b0;
            r_steer       <= '0;
            r_throttle    <= '0;
            r_brake       <= '0;
            r_calib_steer <= '0;
            for (int i = 0; i < 4; i++) begin
                r_reject_cnt[i] <= '0;
            end
            r_out_valid   <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_tele  <= 1'b0;
                        r_echo  <= '0;
                        r_state <= S_EMIT;
                        case (i_item.kind)
                            K_TICK: begin
                                r_status  <= ST_TICK;
                                r_elapsed <= n_elapsed;
                                if (w_timed_out) begin
                                    r_calib       <= 1'b0;
                                    r_calib_steer <= '0;
                                    if (i_cfg.fs_enable) begin
                                        r_failsafe <= 1'b1;
                                        r_armed    <= 1'b0;
                                        r_steer    <= '0;
                                        r_throttle <= '0;
                                        r_brake    <= '0;
                                        r_prev_arm <= 1'b1;
                                    end
                                end
                            end
                            K_CORRUPT: begin
                                r_status        <= ST_CORRUPT;
                                r_reject_cnt[0] <= r_reject_cnt[0] + COUNTER_WIDTH'(1);
                            end
                            K_FOREIGN: begin
                                r_status        <= ST_FOREIGN;
                                r_reject_cnt[1] <= r_reject_cnt[1] + COUNTER_WIDTH'(1);
                            end
                            default: begin
                                if (!w_seq_ok) begin
                                    r_status        <= ST_STALE;
                                    r_reject_cnt[2] <= r_reject_cnt[2] + COUNTER_WIDTH'(1);
                                end else begin
                                    r_status        <= ST_ACCEPT;
                                    r_reject_cnt[3] <= r_reject_cnt[3] + COUNTER_WIDTH'(1);
                                    r_have_seq      <= 1'b1;
                                    r_last_seq      <= i_item.seq;
                                    r_echo          <= i_item.seq;
                                    r_elapsed       <= '0;
                                    r_failsafe      <= 1'b0;
                                    r_calib         <= w_cal_ok;
                                    r_calib_steer   <= w_cal_ok ? w_clamped : 16'sd0;
                                    r_steer         <= i_item.steer;
                                    r_throttle      <= i_item.throttle;
                                    r_brake         <= i_item.brake;
                                    // arm only on a rising edge of the plain armed request
                                    r_armed         <= w_normal_arm && (r_armed || !r_prev_arm);
                                    r_prev_arm      <= w_normal_arm;
                                    if (w_mod_start) begin
                                        r_state <= S_MOD;
                                    end
                                end
                            end
                        endcase
                    end
                end
                S_MOD: begin
                    if (w_mod_done) begin
                        r_tele  <= w_rem_zero;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hdl/control_link_failsafe_arming_unit.sv
// Top level of the control-link failsafe and arming unit.
// Depends on clfa_pkg, clfa_front, clfa_queue, clfa_back (and clfa_mod below it).

// Takes control-packet events and millisecond ticks (tuser = 1) on the slave stream and
// returns one result per item on the master stream, carrying the status code in tuser.
// Ticks, rejected packets and accepted packets whose telemetry divisor is zero pass through
// the queue, the back-end state register and the output register before they are offered,
// and the back end takes a new item only once it has emitted the last; an accepted packet
// with a nonzero divisor also waits for the bit-serial remainder unit, which works sixteen
// sequence bits one per cycle. A two-entry queue behind the input lets new items be taken
// while a result waits on the output.
// Configuration writes land at once and must only be made while the block is idle.
module control_link_failsafe_arming_unit #(
    parameter int COUNTER_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [clfa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [clfa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [79:0]                       s_axis_tdata,  // crc_ok, packet_unit, seq,
                                                             // flag_armed, flag_calibration,
                                                             // steer_in, throttle_in,
                                                             // brake_in, zero fill
    input  logic [0:0]                        s_axis_tuser,  // opcode
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [87:0]                       m_axis_tdata,  // armed, failsafe, calibrating,
                                                             // drive_steer, drive_throttle,
                                                             // drive_brake, calib_steer,
                                                             // telemetry_request, reply_seq,
                                                             // zero fill
    output logic [2:0]                        m_axis_tuser   // status
);
    import clfa_pkg::*;

    t_cfg    r_cfg;
    t_item   w_front_item;
    t_item   w_q_item;
    t_result w_result;
    logic    w_push;
    logic    w_pop;
    logic    w_q_full;
    logic    w_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_unit   <= OWN_UNIT_RST;
            r_cfg.timeout    <= TIMEOUT_RST;
            r_cfg.axis_limit <= AXIS_LIMIT_RST;
            r_cfg.tele_div   <= TELE_DIV_RST;
            r_cfg.fs_enable  <= FS_ENABLE_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_OWN_UNIT:   r_cfg.own_unit   <= i_cfg_data[7:0];
                CFG_TIMEOUT:    r_cfg.timeout    <= i_cfg_data;
                CFG_AXIS_LIMIT: r_cfg.axis_limit <= i_cfg_data[14:0];
                CFG_TELE_DIV:   r_cfg.tele_div   <= i_cfg_data[7:0];
                CFG_FS_ENABLE:  r_cfg.fs_enable  <= i_cfg_data[0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    clfa_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg         (r_cfg),
        .i_q_full      (w_q_full),
        .o_push        (w_push),
        .o_item        (w_front_item)
    );

    clfa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_item  (w_q_item)
    );

    clfa_back #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (w_q_empty),
        .i_item    (w_q_item),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (w_result)
    );

    assign m_axis_tuser = w_result.status;
    assign m_axis_tdata = {4'd0,
                           w_result.reply_seq,
                           w_result.telemetry_request,
                           w_result.calib_steer,
                           w_result.drive_brake,
                           w_result.drive_throttle,
                           w_result.drive_steer,
                           w_result.calibrating,
                           w_result.failsafe,
                           w_result.armed};

    // Failsafe and armed are never reported together
    a_failsafe_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("armed while failsafe active");

    // Calibration is only granted with motors disarmed
    a_calib_disarmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[2]))
        else $error("armed while calibrating");

    // Telemetry and echo only come with an accepted packet
    a_tele_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[67]) |-> (m_axis_tuser == ST_ACCEPT))
        else $error("telemetry requested on a non-accepted item");

    // No result is presented right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

FILE: tb/control_link_failsafe_arming_unit_tb.sv
// Self-checking testbench for control_link_failsafe_arming_unit: packets and ticks in,
// one drive/status transfer out per item, checked against an in-bench model of the link.
// Depends on clfa_pkg and the unit's RTL.
module control_link_failsafe_arming_unit_tb;
    import clfa_pkg::*;

    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_TICK   = 1'b1;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned PRINT_LIMIT = 40;

    typedef enum int unsigned {PACE_FULL, PACE_RANDOM, PACE_BURSTY} t_pace;

    // Slave tdata layout, lowest field last
    typedef struct packed {
        logic [4:0]         pad;
        logic [15:0]        brake;
        logic signed [15:0] throttle;
        logic signed [15:0] steer;
        logic               cal;
        logic               arm;
        logic [15:0]        seq;
        logic [7:0]         unit;
        logic               crc_ok;
    } t_ctrl_word;

    typedef struct packed {
        logic       opcode;
        t_ctrl_word w;
    } t_ctrl_evt;

    // Master tdata layout, lowest field last
    typedef struct packed {
        logic [3:0]         pad;
        logic [15:0]        reply_seq;
        logic               tele;
        logic signed [15:0] calib_steer;
        logic [15:0]        brake;
        logic signed [15:0] throttle;
        logic signed [15:0] steer;
        logic               calibrating;
        logic               failsafe;
        logic               armed;
    } t_drive_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [79:0]           s_axis_tdata = '0;  // crc_ok, packet_unit, seq, flag_armed,
                                               // flag_calibration, steer_in, throttle_in,
                                               // brake_in, zero fill
    logic [0:0]            s_axis_tuser = '0;  // opcode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [87:0]           m_axis_tdata;       // armed, failsafe, calibrating, drive_steer,
                                               // drive_throttle, drive_brake, calib_steer,
                                               // telemetry_request, reply_seq, zero fill
    logic [2:0]            m_axis_tuser;       // status

    control_link_failsafe_arming_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Link model state and register copy
    t_cfg               link_cfg;
    logic               seq_valid;
    logic [15:0]        seq_last;
    logic [16:0]        link_age;
    logic               fs_on;
    logic               armed_on;
    logic               arm_req_prev;
    logic               cal_on;
    logic signed [15:0] hold_steer;
    logic signed [15:0] hold_throttle;
    logic [15:0]        hold_brake;
    logic signed [15:0] hold_calib;

    t_ctrl_evt   ctrl_stim_q[$];
    t_result     drive_expect_q[$];

    int unsigned items_queued = 0;
    int unsigned items_taken = 0;
    int unsigned res_count = 0;
    int unsigned fail_count = 0;
    int unsigned quiet_cycles = 0;
    logic        in_taken = 1'b0;
    logic        out_taken = 1'b0;
    int unsigned tx_gap = 0;
    int unsigned rx_wait = 0;
    t_pace       tx_pace = PACE_FULL;
    t_pace       rx_pace = PACE_FULL;
    logic [15:0] gen_seq;

    function automatic int unsigned draw_wait(input t_pace pace);
        case (pace)
            PACE_FULL:   return 0;
            PACE_RANDOM: return $urandom_range(0, 17);
            default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
        endcase
    endfunction

    // Apply one event to the link model and return the transfer it produces
    function automatic t_result link_predict(input t_ctrl_evt ev);
        t_result            r;
        logic signed [15:0] diff;
        logic signed [16:0] lim;
        logic signed [16:0] neg_lim;
        logic signed [16:0] st;
        logic               cal_ok;
        logic               normal_arm;
        r = '0;
        if (ev.opcode == OP_TICK) begin
            r.status = ST_TICK;
            if (link_age != ELAPSED_MAX) link_age = link_age + 1'b1;
            if (link_age > {1'b0, link_cfg.timeout}) begin
                cal_on = 1'b0;
                hold_calib = '0;
                if (link_cfg.fs_enable) begin
                    fs_on = 1'b1;
                    armed_on = 1'b0;
                    hold_steer = '0;
                    hold_throttle = '0;
                    hold_brake = '0;
                    arm_req_prev = 1'b1;
                end
            end
        end else if (!ev.w.crc_ok) begin
            r.status = ST_CORRUPT;
        end else if (ev.w.unit != link_cfg.own_unit) begin
            r.status = ST_FOREIGN;
        end else begin
            diff = ev.w.seq - seq_last;
            // forward step or a backward jump past the restart window
            if (seq_valid && !(diff > 0 || diff < NEG_RESTART_JUMP)) begin
                r.status = ST_STALE;
            end else begin
                seq_valid = 1'b1;
                seq_last = ev.w.seq;
                cal_ok = ev.w.cal && !ev.w.arm && !armed_on &&
                         ev.w.throttle == 0 && ev.w.brake == 0;
                normal_arm = ev.w.arm && !ev.w.cal;
                r.status = ST_ACCEPT;
                link_age = '0;
                fs_on = 1'b0;
                cal_on = cal_ok;
                lim = {2'b00, link_cfg.axis_limit};
                neg_lim = -lim;
                st = ev.w.steer;
                if (!cal_ok) hold_calib = '0;
                else if (st > lim) hold_calib = lim[15:0];
                else if (st < neg_lim) hold_calib = neg_lim[15:0];
                else hold_calib = ev.w.steer;
                hold_steer = ev.w.steer;
                hold_throttle = ev.w.throttle;
                hold_brake = ev.w.brake;
                if (normal_arm) begin
                    if (!arm_req_prev) armed_on = 1'b1;
                end else begin
                    armed_on = 1'b0;
                end
                arm_req_prev = normal_arm;
                r.telemetry_request = link_cfg.tele_div != 0 &&
                                      (ev.w.seq % link_cfg.tele_div) == 0;
                r.reply_seq = ev.w.seq;
            end
        end
        r.armed = armed_on;
        r.failsafe = fs_on;
        r.calibrating = cal_on;
        r.drive_steer = hold_steer;
        r.drive_throttle = hold_throttle;
        r.drive_brake = hold_brake;
        r.calib_steer = hold_calib;
        return r;
    endfunction

    function automatic t_ctrl_evt make_evt(input logic op, input logic crc,
                                           input logic [7:0] unit, input logic [15:0] seq,
                                           input logic arm, input logic cal,
                                           input logic [15:0] steer, input logic [15:0] thr,
                                           input logic [15:0] brake);
        t_ctrl_evt e;
        e = '0;
        e.opcode = op;
        e.w.crc_ok = crc;
        e.w.unit = unit;
        e.w.seq = seq;
        e.w.arm = arm;
        e.w.cal = cal;
        e.w.steer = steer;
        e.w.throttle = thr;
        e.w.brake = brake;
        return e;
    endfunction

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        if (fail_count < PRINT_LIMIT)
            $display("mismatch on %s at transfer %0d: got %h, want %h",
                     field, res_count, got, want);
        fail_count++;
    endtask

    task automatic queue_evt(input t_ctrl_evt e);
        ctrl_stim_q.push_back(e);
        items_queued++;
    endtask

    // Hold until every queued item went in and every result came back
    task automatic wait_drained();
        while (!(items_taken == items_queued && drive_expect_q.size() == 0))
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_OWN_UNIT:   link_cfg.own_unit = val[7:0];
            CFG_TIMEOUT:    link_cfg.timeout = val;
            CFG_AXIS_LIMIT: link_cfg.axis_limit = val[14:0];
            CFG_TELE_DIV:   link_cfg.tele_div = val[7:0];
            CFG_FS_ENABLE:  link_cfg.fs_enable = val[0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [7:0] own, input logic [15:0] tmo,
                                 input logic [14:0] lim, input logic [7:0] div,
                                 input logic fs);
        write_reg(CFG_OWN_UNIT, {8'd0, own});
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_AXIS_LIMIT, {1'b0, lim});
        write_reg(CFG_TELE_DIV, {8'd0, div});
        write_reg(CFG_FS_ENABLE, {15'd0, fs});
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Driver: offer one queued item per transfer, with a drawn gap after each
    always @(negedge i_clk) begin
        t_ctrl_evt ev;
        logic      offer;
        offer = s_axis_tvalid && !in_taken;
        if (!i_rst_n) begin
            offer = 1'b0;
        end else if (!offer) begin
            if (tx_gap != 0) begin
                tx_gap = tx_gap - 1;
            end else if (ctrl_stim_q.size() != 0) begin
                ev = ctrl_stim_q.pop_front();
                s_axis_tdata <= ev.w;
                s_axis_tuser <= ev.opcode;
                offer = 1'b1;
                if ($urandom_range(0, 49) == 0) tx_pace = t_pace'($urandom_range(0, 2));
                tx_gap = draw_wait(tx_pace);
            end
        end
        s_axis_tvalid <= offer;
    end

    // Receiver: drawn stall after each result, plus two long hold-offs
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (out_taken) begin
                if ($urandom_range(0, 39) == 0) rx_pace = t_pace'($urandom_range(0, 2));
                rx_wait = draw_wait(rx_pace);
                // hold long enough for the unit to back up into the sender
                if (res_count == 300 || res_count == 1100) rx_wait = 400;
            end
            if (rx_wait != 0) begin
                rx_wait = rx_wait - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Monitor: predict on each input transfer, check each output transfer
    always @(posedge i_clk) begin
        t_ctrl_evt   seen;
        t_drive_word got;
        t_result     want;
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        out_taken <= i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            seen.opcode = s_axis_tuser[0];
            seen.w = s_axis_tdata;
            drive_expect_q.push_back(link_predict(seen));
            items_taken <= items_taken + 1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            res_count <= res_count + 1;
            if (drive_expect_q.size() == 0) begin
                report_mismatch("unexpected transfer", {13'd0, m_axis_tuser}, '0);
            end else begin
                want = drive_expect_q.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", m_axis_tuser, want.status);
                if (got.armed !== want.armed)
                    report_mismatch("armed", got.armed, want.armed);
                if (got.failsafe !== want.failsafe)
                    report_mismatch("failsafe", got.failsafe, want.failsafe);
                if (got.calibrating !== want.calibrating)
                    report_mismatch("calibrating", got.calibrating, want.calibrating);
                if (got.steer !== want.drive_steer)
                    report_mismatch("drive_steer", got.steer, want.drive_steer);
                if (got.throttle !== want.drive_throttle)
                    report_mismatch("drive_throttle", got.throttle, want.drive_throttle);
                if (got.brake !== want.drive_brake)
                    report_mismatch("drive_brake", got.brake, want.drive_brake);
                if (got.calib_steer !== want.calib_steer)
                    report_mismatch("calib_steer", got.calib_steer, want.calib_steer);
                if (got.tele !== want.telemetry_request)
                    report_mismatch("telemetry_request", got.tele, want.telemetry_request);
                if (got.reply_seq !== want.reply_seq)
                    report_mismatch("reply_seq", got.reply_seq, want.reply_seq);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            i_cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_ctrl_evt ev;
        int        p;
        int        k;
        int        pick;

        link_cfg.own_unit = OWN_UNIT_RST;
        link_cfg.timeout = TIMEOUT_RST;
        link_cfg.axis_limit = AXIS_LIMIT_RST;
        link_cfg.tele_div = TELE_DIV_RST;
        link_cfg.fs_enable = FS_ENABLE_RST;
        seq_valid = 1'b0;
        seq_last = '0;
        link_age = ELAPSED_RST;
        fs_on = 1'b1;
        armed_on = 1'b0;
        arm_req_prev = 1'b1;
        cal_on = 1'b0;
        hold_steer = '0;
        hold_throttle = '0;
        hold_brake = '0;
        hold_calib = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: tick past the default timeout, then a corrupt packet
        queue_evt(make_evt(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_evt(make_evt(OP_PACKET, 0, 8'h01, 16'h1234, 1, 0, 16'h0100, 0, 0));
        wait_drained();

        load_settings(8'hA5, 16'd3, 15'd100, 8'd5, 1'b1);
        queue_evt(make_evt(OP_PACKET, 1, 8'h5A, 16'h0000, 0, 0, 0, 0, 0));
        // first packet, drive extremes, seq that qualifies for telemetry
        queue_evt(make_evt(OP_PACKET, 1, 8'hA5, 16'hFFFF, 0, 0, 16'h7FFF, 16'h8000, 16'hFFFF));
        queue_evt(make_evt(OP_PACKET, 1, 8'hA5, 16'hFFFF, 1, 0, 0, 0, 0));
        queue_evt(make_evt(OP_PACKET, 1, 8'hA5, 16'h0000, 1, 0, 16'h0010, 16'h0020, 0));
        // armed together with calibration never counts as armed
        queue_evt(make_evt(OP_PACKET, 1, 8'hA5, 16'h0001, 1, 1, 0, 0, 0));
        queue_evt(make_evt(OP_PACKET, 1, 8'hA5, 16'h0002, 0, 1, 16'h8000, 0, 0));
        queue_evt(make_evt(OP_PACKET, 1, 8'hA5, 16'h0003, 0, 1, 16'h7FFF, 0, 0));
        repeat (4) queue_evt(make_evt(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        // backward by exactly the restart window is stale, one more is a restart
        queue_evt(make_evt(OP_PACKET, 1, 8'hA5, 16'hFC1B, 0, 0, 0, 0, 0));
        queue_evt(make_evt(OP_PACKET, 1, 8'hA5, 16'hFC1A, 0, 0, 0, 0, 0));
        queue_evt(make_evt(OP_PACKET, 1, 8'hA5, 16'h7C1A, 0, 0, 0, 0, 0));
        queue_evt(make_evt(OP_PACKET, 1, 8'hA5, 16'h7C1B, 0, 0, 0, 0, 0));
        queue_evt(make_evt(OP_PACKET, 1, 8'hA5, 16'h7C1C, 1, 0, 0, 0, 0));
        // calibration asked while still armed is refused
        queue_evt(make_evt(OP_PACKET, 1, 8'hA5, 16'h7C1D, 0, 1, 16'h0005, 0, 0));
        queue_evt(make_evt(OP_PACKET, 1, 8'hA5, 16'h7C1E, 1, 0, 0, 0, 0));
        queue_evt(make_evt(OP_TICK, 1, 8'hFF, 16'hFFFF, 1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        wait_drained();

        for (p = 0; p < 8; p++) begin
            case (p)
                0: load_settings(8'h00, 16'd1, 15'd0, 8'd1, 1'b1);
                1: load_settings(8'hFF, 16'hFFFF, 15'h7FFF, 8'd255, 1'b0);
                2: load_settings($urandom, 16'd0, $urandom, 8'd0, 1'b1);
                3: load_settings($urandom, $urandom_range(2, 12), $urandom,
                                 $urandom_range(1, 255), 1'b0);
                4: load_settings(OWN_UNIT_RST, TIMEOUT_RST, AXIS_LIMIT_RST, TELE_DIV_RST,
                                 FS_ENABLE_RST);
                default: load_settings($urandom, $urandom_range(1, 20), $urandom,
                                       $urandom_range(1, 16), $urandom);
            endcase
            gen_seq = seq_last;
            for (k = 0; k < 200; k++) begin
                pick = $urandom_range(0, 99);
                ev.opcode = OP_PACKET;
                ev.w = {$urandom, $urandom, $urandom};
                ev.w.pad = '0;
                if (pick < 30) begin
                    ev.opcode = OP_TICK;
                end else if (pick < 95) begin
                    ev.w.crc_ok = 1'b1;
                    ev.w.unit = link_cfg.own_unit;
                    if (pick < 80) begin
                        gen_seq = gen_seq + $urandom_range(1, 3);
                        ev.w.seq = gen_seq;
                        ev.w.arm = $urandom_range(0, 1);
                        ev.w.cal = ($urandom_range(0, 3) == 0);
                        if ($urandom_range(0, 1)) begin
                            ev.w.throttle = '0;
                            ev.w.brake = '0;
                        end
                        if ($urandom_range(0, 7) == 0)
                            ev.w.steer = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    end else if (pick < 85) begin
                        ev.w.crc_ok = 1'b0;
                    end else if (pick < 90) begin
                        ev.w.unit = link_cfg.own_unit ^ (8'd1 << $urandom_range(0, 7));
                    end else begin
                        ev.w.seq = gen_seq - $urandom_range(0, 1000);
                    end
                end else if (pick < 98) begin
                    // peer restart: jump back past the window
                    ev.w.crc_ok = 1'b1;
                    ev.w.unit = link_cfg.own_unit;
                    ev.w.seq = gen_seq - $urandom_range(1001, 32768);
                    gen_seq = ev.w.seq;
                end
                queue_evt(ev);
            end
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (drive_expect_q.size() != 0)
            report_mismatch("results missing", drive_expect_q.size(), '0);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
